/* src/fbd_pkg.sv */
// package for the fractional baud divisor calculator
// types and constants shared by every file, and the exponent limit table
// depends on nothing
package fbd_pkg;

  localparam int unsigned CLOCK_W   = 26;
  localparam int unsigned RATE_W    = 32;
  localparam int unsigned DIV_W     = 12;
  localparam int unsigned EXP_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned LIMIT_W   = 22;
  localparam int unsigned CNT_W     = 5;

  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 26'd32000000;

  // exponent search index: index 0 is exponent -7, the last index is exponent 7
  localparam logic [IDX_W-1:0] IDX_LAST    = 4'd14;
  // index of exponent -3, the last one using the shifted-remainder formula
  localparam logic [IDX_W-1:0] IDX_EXP_M3  = 4'd4;
  // index of exponent 0, the first one using the plain clock formula
  localparam logic [IDX_W-1:0] IDX_EXP_0   = 4'd7;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_HZ     = 1'b0,
    REG_DOUBLE_SPEED = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CLOCK_W-1:0] clock_hz;
    logic               double_speed;
  } cfg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RATIO,
    ST_SEARCH,
    ST_PREP,
    ST_DIVIDE,
    ST_FIN
  } state_t;

  // request to and response from the shared divider
  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] num;
    logic [RATE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] quot;
  } div_rsp_t;

  // clock/rate limit checked at each exponent step
  function automatic logic [LIMIT_W-1:0] exp_limit(input logic [IDX_W-1:0] idx);
    logic [LIMIT_W-1:0] lim;
    lim = '0;
    if (idx <= IDX_EXP_M3) begin
      lim = (LIMIT_W'(256) << idx) - LIMIT_W'(1);
    end else begin
      lim = LIMIT_W'(4095) << (idx - IDX_EXP_M3);
    end
    return lim;
  endfunction

endpackage

/* src/fbd_if.sv */
// item channels of the fractional baud divisor calculator
// valid/ready handshake with the request and result payloads
// depends on fbd_pkg
interface fbd_in_if;
  import fbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] baud_rate;

  modport source (output valid, output baud_rate, input ready);
  modport sink (input valid, input baud_rate, output ready);
endinterface

interface fbd_out_if;
  import fbd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    rate_ok;
  logic [DIV_W-1:0]        divisor;
  logic signed [EXP_W-1:0] scale_exp;

  modport source (output valid, output rate_ok, output divisor, output scale_exp,
                  input ready);
  modport sink (input valid, input rate_ok, input divisor, input scale_exp,
                output ready);
endinterface

/* src/fbd_divider.sv */
// shared restoring divider, one quotient bit per cycle
// depends on fbd_pkg
module fbd_divider (
  input  logic             clk,
  input  logic             rst,
  input  fbd_pkg::div_req_t req,
  output fbd_pkg::div_rsp_t rsp
);
  import fbd_pkg::*;

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [RATE_W:0]     rem;
  logic [RATE_W-1:0]   dvd;
  logic [RATE_W-1:0]   den;
  logic [RATE_W:0]     trial;
  logic [RATE_W:0]     diff;

  // one trial subtraction per cycle
  assign trial = {rem[RATE_W-1:0], dvd[RATE_W-1]};
  assign diff  = trial - {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == '1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == '1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= diff[RATE_W] ? trial : diff;
      dvd <= {dvd[RATE_W-2:0], ~diff[RATE_W]};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;

endmodule

/* src/fbd_ctrl.sv */
// sequencer: range check, exponent search and divisor setup around the divider
// holds the result register of the output channel
// depends on fbd_pkg, fbd_if
module fbd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  fbd_pkg::cfg_t     cfg,
  fbd_in_if.sink            rate,
  fbd_out_if.source         result,
  output fbd_pkg::div_req_t div_req,
  input  fbd_pkg::div_rsp_t div_rsp
);
  import fbd_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [RATE_W-1:0]   rate_q;
  logic [RATE_W-1:0]   rate_w;
  logic [RATE_W-1:0]   ratio;
  logic [IDX_W-1:0]    idx;
  logic                res_ok;
  logic [DIV_W-1:0]    res_div;
  logic [EXP_W-1:0]    res_exp;

  logic                accept;
  logic                out_free;
  logic [CLOCK_W-1:0]  hi;
  logic [CLOCK_W-1:0]  lo;
  logic                rate_bad;
  logic [RATE_W-1:0]   rate_eff;
  logic                found;
  logic [RATE_W-1:0]   clk_ext;
  logic [RATE_W-1:0]   c_val;
  logic [IDX_W-1:0]    up_sh;
  logic [IDX_W-1:0]    dn_sh;
  logic [RATE_W-1:0]   r_val;
  logic [RATE_W-1:0]   num_div;
  logic [RATE_W-1:0]   den_div;
  logic [RATE_W-1:0]   quot_adj;

  assign accept   = rate.valid && rate.ready;
  assign out_free = !result.valid || result.ready;

  // rate bounds, halved without double speed
  assign hi = cfg.double_speed ? (cfg.clock_hz >> 3) : (cfg.clock_hz >> 4);
  assign lo = cfg.double_speed ? (cfg.clock_hz >> 22) : (cfg.clock_hz >> 23);
  assign rate_bad = (rate_q == '0) || (rate_q > RATE_W'(hi)) || (rate_q < RATE_W'(lo));
  assign rate_eff = cfg.double_speed ? rate_q : (rate_q << 1);

  // exponent search stops at the first limit above clock/rate, or at the last exponent
  assign found = (idx == IDX_LAST) || (ratio < RATE_W'(exp_limit(idx)));

  // divisor operands for the chosen exponent
  assign clk_ext = RATE_W'(cfg.clock_hz);
  assign c_val   = clk_ext - (rate_w << 3);
  assign up_sh   = idx - IDX_EXP_M3;
  assign dn_sh   = IDX_EXP_M3 - idx;
  assign r_val   = rate_w << up_sh;

  always_comb begin
    if (idx <= IDX_EXP_M3) begin
      num_div = (c_val << dn_sh) + (rate_w >> 1);
      den_div = rate_w;
    end else if (idx < IDX_EXP_0) begin
      num_div = c_val + (r_val >> 1);
      den_div = r_val;
    end else begin
      num_div = clk_ext + (r_val >> 1);
      den_div = r_val;
    end
  end

  assign quot_adj = (idx >= IDX_EXP_0) ? (div_rsp.quot - RATE_W'(1)) : div_rsp.quot;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_CHECK;
      ST_CHECK:  state_next = rate_bad ? ST_FIN : ST_RATIO;
      ST_RATIO:  if (div_rsp.done) state_next = ST_SEARCH;
      ST_SEARCH: if (found) state_next = ST_PREP;
      ST_PREP:   state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_rsp.done) state_next = ST_FIN;
      ST_FIN:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    rate.ready    = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = num_div;
    div_req.den   = den_div;
    unique case (state)
      ST_IDLE:  rate.ready = 1'b1;
      ST_CHECK: begin
        div_req.start = !rate_bad;
        div_req.num   = clk_ext;
        div_req.den   = rate_eff;
      end
      ST_PREP:  div_req.start = 1'b1;
      ST_RATIO, ST_SEARCH, ST_DIVIDE, ST_FIN: ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rate_q <= rate.baud_rate;
    end
    if (state == ST_CHECK) begin
      rate_w  <= rate_eff;
      idx     <= '0;
      res_ok  <= !rate_bad;
      res_div <= '0;
      res_exp <= '0;
    end
    if (state == ST_RATIO && div_rsp.done) begin
      ratio <= div_rsp.quot;
    end
    if (state == ST_SEARCH && !found) begin
      idx <= idx + IDX_W'(1);
    end
    if (state == ST_DIVIDE && div_rsp.done) begin
      res_div <= quot_adj[DIV_W-1:0];
      res_exp <= idx - IDX_EXP_0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      result.rate_ok   <= res_ok;
      result.divisor   <= res_div;
      result.scale_exp <= $signed(res_exp);
    end
  end

endmodule

/* src/fractional_baud_divisor_calc_top.sv */
// Fractional baud divisor calculator, top level.
// Channels: rate carries one requested baud rate per item, result carries
// rate_ok, the 12-bit divisor and the signed scale exponent for it. Both use a
// valid/ready handshake; an item moves at a clock edge with both high.
// Configuration: cfg_we writes cfg_data into register cfg_idx (0 = clock_hz,
// 1 = double_speed) at the clock edge; write only while no item is in flight.
// A rejected rate goes from the check state through the finish state to the
// output register. An accepted rate runs two divisions on the shared
// one-bit-per-cycle divider (clock/rate, then the divisor) with the exponent
// search between them. One item is worked on at a time; rate is ready only
// while the sequencer is idle, so a new item is taken only after the last
// result has entered the output register. A result waits in the output
// register while the receiver stalls; the next item can be taken meanwhile
// but its result waits for the register.
// Reset (rst, synchronous) empties the output register, returns to idle and
// loads clock_hz = 32000000 and double_speed = 1.
// depends on fbd_pkg, fbd_if, fbd_divider, fbd_ctrl
module fractional_baud_divisor_calc_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fbd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fbd_pkg::CLOCK_W-1:0]   cfg_data,
  fbd_in_if.sink                        rate,
  fbd_out_if.source                     result
);
  import fbd_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_hz     <= CLOCK_RESET;
      cfg.double_speed <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_CLOCK_HZ:     cfg.clock_hz     <= cfg_data;
        REG_DOUBLE_SPEED: cfg.double_speed <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  fbd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .rate    (rate),
    .result  (result),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  fbd_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

`ifndef NO_ASSERTIONS
  // a rejected rate reports zero settings
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.rate_ok) |->
      (result.divisor == '0 && result.scale_exp == '0))
    else $error("rejected rate with nonzero settings");

  // the exponent never takes the unused code -8
  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.scale_exp != -4'sd8))
    else $error("scale exponent out of range");

  // the block is busy right after it takes an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (rate.valid && rate.ready) |=> !rate.ready)
    else $error("ready right after accepting an item");

  // the divider is never restarted in the same cycle it reports done
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.done)
    else $error("divider started while finishing");
`endif

endmodule

/* test/fractional_baud_divisor_calc_top_tb.sv */
// testbench for the fractional baud divisor calculator top level
// predicts rate_ok, divisor and scale exponent per requested rate and checks every result item
// depends on fbd_pkg, fbd_if and fractional_baud_divisor_calc_top
module fractional_baud_divisor_calc_top_tb;
  import fbd_pkg::*;

  typedef struct packed {
    logic                    rate_ok;
    logic [DIV_W-1:0]        divisor;
    logic signed [EXP_W-1:0] scale_exp;
  } baud_setting_t;

  localparam int unsigned STALL_LIMIT       = 2000;
  localparam int unsigned NUM_SETTINGS      = 12;
  localparam int unsigned ITEMS_PER_SETTING = 72;
  localparam logic [CLOCK_W-1:0] CLOCK_MAX  = {CLOCK_W{1'b1}};

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CLOCK_W-1:0]   cfg_data;

  fbd_in_if  rate_if ();
  fbd_out_if res_if ();

  fractional_baud_divisor_calc_top DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .rate     (rate_if),
    .result   (res_if)
  );

  // shadow of the configuration registers
  logic [CLOCK_W-1:0] cur_clock_hz     = CLOCK_RESET;
  logic               cur_double_speed = 1'b1;

  baud_setting_t pending_settings [$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles   = 0;
  bit            idling_on      = 1'b1;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // accepted rate bounds for the current setting
  function automatic logic [63:0] rate_bound(input bit upper);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = 64'(cur_clock_hz) / 64'd8;
    lo = 64'(cur_clock_hz) / 64'd4194304;
    if (!cur_double_speed) begin
      hi = hi / 64'd2;
      lo = lo / 64'd2;
    end
    return upper ? hi : lo;
  endfunction

  // expected divisor and exponent for one requested rate
  function automatic baud_setting_t calc_setting(input logic [RATE_W-1:0] baud);
    logic [63:0]   rate;
    logic [63:0]   clk64;
    logic [63:0]   limit;
    logic [63:0]   ratio;
    logic [63:0]   quo;
    logic [63:0]   r;
    logic [63:0]   c;
    int            e;
    baud_setting_t s;
    s     = '0;
    clk64 = 64'(cur_clock_hz);
    rate  = 64'(baud);
    if (rate == 0 || rate > rate_bound(1'b1) || rate < rate_bound(1'b0)) begin
      return s;
    end
    if (!cur_double_speed) begin
      rate = rate * 64'd2;
    end
    // lowest exponent whose limit exceeds clock/rate, capped at exponent 7
    limit = 64'd255;
    ratio = clk64 / rate;
    e     = -7;
    while (e < 7 && ratio >= limit) begin
      limit = limit << 1;
      if (e < -3) begin
        limit = limit | 64'd1;
      end
      e++;
    end
    // rounded divisor, three ranges of the exponent
    if (e < 0) begin
      c = clk64 - 64'd8 * rate;
      if (e <= -3) begin
        quo = ((c << (-e - 3)) + rate / 64'd2) / rate;
      end else begin
        r   = rate << (e + 3);
        quo = (c + r / 64'd2) / r;
      end
    end else begin
      r   = rate << (e + 3);
      quo = (clk64 + r / 64'd2) / r - 64'd1;
    end
    s.rate_ok   = 1'b1;
    s.divisor   = quo[DIV_W-1:0];
    s.scale_exp = e[EXP_W-1:0];
    return s;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (!idling_on || sel < 50) begin
      return 0;
    end
    if (sel < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // random rate: mostly inside the accepted range, spread over magnitudes
  function automatic logic [RATE_W-1:0] pick_rate();
    logic [63:0]       hi;
    logic [63:0]       lo;
    logic [RATE_W-1:0] v;
    logic [RATE_W-1:0] t;
    int unsigned       sel;
    int unsigned       tries;
    bit                found;
    hi  = rate_bound(1'b1);
    lo  = rate_bound(1'b0);
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      v = '0;
    end else if (sel < 10) begin
      v = RATE_W'($urandom_range(0, 16));
    end else if (sel < 20) begin
      v = $urandom;
    end else if (sel < 30) begin
      case ($urandom_range(0, 3))
        0: begin
          v = RATE_W'(lo);
        end
        1: begin
          v = RATE_W'(hi);
        end
        2: begin
          v = RATE_W'(lo - 64'd1);
        end
        default: begin
          v = RATE_W'(hi + 64'd1);
        end
      endcase
    end else begin
      v     = RATE_W'(hi);
      found = 1'b0;
      tries = 0;
      while (!found && tries < 64) begin
        t = $urandom >> $urandom_range(0, 31);
        if (t != 0 && 64'(t) >= lo && 64'(t) <= hi) begin
          v     = t;
          found = 1'b1;
        end
        tries++;
      end
    end
    return v;
  endfunction

  // result side stalls
  initial begin : result_stall
    int unsigned n;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      n = pick_gap();
      if (n == 0) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
        res_if.ready <= 1'b1;
      end
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : check_results
    baud_setting_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_settings.size() == 0) begin
        $error("unexpected result item: rate_ok %0b divisor %0d scale_exp %0d",
               res_if.rate_ok, res_if.divisor, res_if.scale_exp);
        mismatch_count++;
      end else begin
        want = pending_settings.pop_front();
        if (res_if.rate_ok !== want.rate_ok) begin
          $error("rate_ok mismatch: expected %0b, actual %0b", want.rate_ok, res_if.rate_ok);
          mismatch_count++;
        end
        if (res_if.divisor !== want.divisor) begin
          $error("divisor mismatch: expected %0d, actual %0d", want.divisor, res_if.divisor);
          mismatch_count++;
        end
        if (res_if.scale_exp !== want.scale_exp) begin
          $error("scale_exp mismatch: expected %0d, actual %0d",
                 want.scale_exp, res_if.scale_exp);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (rate_if.valid && rate_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // send one rate item and queue its expected setting
  task automatic send_rate(input logic [RATE_W-1:0] baud);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      rate_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rate_if.valid     <= 1'b1;
    rate_if.baud_rate <= baud;
    do @(posedge clk); while (!rate_if.ready);
    pending_settings.push_back(calc_setting(baud));
  endtask

  // wait until every expected result item has arrived
  task automatic drain_results();
    rate_if.valid <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CLOCK_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_CLOCK_HZ) begin
      cur_clock_hz = data;
    end else begin
      cur_double_speed = data[0];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // new setting, only while nothing is in flight; upper data bits of double_speed are noise
  task automatic set_config(input logic [CLOCK_W-1:0] clock_hz, input logic double_speed);
    drain_results();
    write_reg(REG_CLOCK_HZ, clock_hz);
    write_reg(REG_DOUBLE_SPEED, (CLOCK_W'($urandom) & ~CLOCK_W'(1)) | CLOCK_W'(double_speed));
  endtask

  // rates just inside and just outside both bounds
  task automatic send_edges();
    logic [63:0] hi;
    logic [63:0] lo;
    hi = rate_bound(1'b1);
    lo = rate_bound(1'b0);
    send_rate(RATE_W'(lo - 64'd1));
    send_rate(RATE_W'(lo));
    send_rate(RATE_W'(hi));
    send_rate(RATE_W'(hi + 64'd1));
  endtask

  // one rate per exponent -7..7 at the reset setting (32 MHz, double speed)
  task automatic test_exponent_sweep();
    logic [RATE_W-1:0] sweep [15] = '{
      32'd160000, 32'd80000, 32'd40000, 32'd20000, 32'd10667, 32'd5333, 32'd2667,
      32'd1067, 32'd533, 32'd267, 32'd128, 32'd64, 32'd32, 32'd16, 32'd11
    };
    foreach (sweep[i]) begin
      send_rate(sweep[i]);
    end
  endtask

  // zero rate, field extremes and range bounds in several settings
  task automatic test_rate_limits();
    send_rate('0);
    send_rate(RATE_W'(1));
    send_rate({RATE_W{1'b1}});
    send_edges();
    set_config(CLOCK_RESET, 1'b0);
    send_edges();
    set_config(CLOCK_MAX, 1'b1);
    send_edges();
  endtask

  // random rates over a series of settings, extremes first
  task automatic test_random_settings();
    logic [CLOCK_W-1:0] clock_hz;
    logic               double_speed;
    for (int k = 0; k < NUM_SETTINGS; k++) begin
      case (k)
        0: begin
          clock_hz     = CLOCK_RESET;
          double_speed = 1'b1;
        end
        1: begin
          clock_hz     = CLOCK_RESET;
          double_speed = 1'b0;
        end
        2: begin
          clock_hz     = CLOCK_MAX;
          double_speed = 1'b1;
        end
        3: begin
          clock_hz     = CLOCK_MAX;
          double_speed = 1'b0;
        end
        4: begin
          clock_hz     = CLOCK_W'(16);
          double_speed = 1'b1;
        end
        5: begin
          clock_hz     = CLOCK_W'(1);
          double_speed = 1'b0;
        end
        default: begin
          clock_hz     = CLOCK_W'($urandom >> (6 + $urandom_range(0, 25)));
          double_speed = 1'($urandom_range(0, 1));
          if (clock_hz == 0) begin
            clock_hz = CLOCK_W'(1);
          end
        end
      endcase
      set_config(clock_hz, double_speed);
      // some settings run with no idling at all
      idling_on = (k != 0) && ($urandom_range(0, 3) != 0);
      repeat (ITEMS_PER_SETTING) send_rate(pick_rate());
    end
    idling_on = 1'b1;
  endtask

  // reset, tests in turn, final verdict
  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_CLOCK_HZ;
    cfg_data          <= '0;
    rate_if.valid     <= 1'b0;
    rate_if.baud_rate <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_exponent_sweep();
    test_rate_limits();
    test_random_settings();
    drain_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
